// ----- rtl/ffpp_pkg.sv -----
// Shared types and constants for the feature frame packet parser.
`default_nettype none

package ffpp_pkg;

   localparam int FEATURE_WORDS      = 16;
   localparam int MAX_SPECTRUM_WORDS = 256;
   localparam int MAX_WAVEFORM_WORDS = 256;

   localparam int MAX_SECTION_WORDS_A =
      (FEATURE_WORDS > MAX_SPECTRUM_WORDS) ? FEATURE_WORDS : MAX_SPECTRUM_WORDS;
   localparam int MAX_SECTION_WORDS =
      (MAX_SECTION_WORDS_A > MAX_WAVEFORM_WORDS) ? MAX_SECTION_WORDS_A : MAX_WAVEFORM_WORDS;
   // section lengths and in-section word counters
   localparam int LEN_WIDTH = $clog2(MAX_SECTION_WORDS + 1);

   localparam int HEADER_BYTES = 56;
   localparam int POS_WIDTH    = $clog2(HEADER_BYTES);

   // header offsets of the last byte of each field
   localparam logic [POS_WIDTH-1:0] POS_MAGIC     = POS_WIDTH'(3);
   localparam logic [POS_WIDTH-1:0] POS_VERSION   = POS_WIDTH'(5);
   localparam logic [POS_WIDTH-1:0] POS_FLAGS     = POS_WIDTH'(7);
   localparam logic [POS_WIDTH-1:0] POS_SEQUENCE  = POS_WIDTH'(11);
   localparam logic [POS_WIDTH-1:0] POS_TIMESTAMP = POS_WIDTH'(15);
   localparam logic [POS_WIDTH-1:0] POS_BEAT      = POS_WIDTH'(23);
   localparam logic [POS_WIDTH-1:0] POS_ONSET     = POS_WIDTH'(31);
   localparam logic [POS_WIDTH-1:0] POS_DROP      = POS_WIDTH'(39);
   localparam logic [POS_WIDTH-1:0] POS_SECTION   = POS_WIDTH'(47);
   localparam logic [POS_WIDTH-1:0] POS_COUNTS    = POS_WIDTH'(HEADER_BYTES - 1);

   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAGIC   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERSION = 1'b1;

   typedef enum logic [1:0] {
      RT_FIELD  = 2'd0,
      RT_WORD   = 2'd1,
      RT_STATUS = 2'd2
   } result_kind_type;

   typedef enum logic [2:0] {
      FID_FLAGS     = 3'd0,
      FID_SEQUENCE  = 3'd1,
      FID_TIMESTAMP = 3'd2,
      FID_BEAT      = 3'd3,
      FID_ONSET     = 3'd4,
      FID_DROP      = 3'd5,
      FID_SECTION   = 3'd6
   } field_id_type;

   typedef enum logic [1:0] {
      SEC_FEATURES = 2'd0,
      SEC_SPECTRUM = 2'd1,
      SEC_WAVEFORM = 2'd2
   } section_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_MAGIC      = 3'd1,
      ST_VERSION    = 3'd2,
      ST_TRUNCATED  = 3'd3,
      ST_DIMENSIONS = 3'd4,
      ST_SIZE       = 3'd5
   } status_type;

   typedef struct packed {
      result_kind_type result_type;
      field_id_type    field_id;
      section_type     section;
      logic [7:0]      word_index;
      logic [63:0]     value;
      status_type      status;
      logic            run_last;
   } rsp_item_type;

   // results caused by one accepted byte, packed from the front
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_batch_type;

endpackage

`default_nettype wire

// ----- rtl/ffpp_parser.sv -----
// Per-byte header/payload parser: packet state and result generation.
`default_nettype none

module ffpp_parser import ffpp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    in_byte,
   input  logic          in_last,
   input  logic [31:0]   expected_magic,
   input  logic [15:0]   expected_version,
   output rsp_batch_type batch
);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [1:0]             lane_ff, lane_in;
   logic [63:0]            asm_ff, asm_in;
   logic [LEN_WIDTH-1:0]   spec_len_ff, spec_len_in;
   logic [LEN_WIDTH-1:0]   wave_len_ff, wave_len_in;
   logic [LEN_WIDTH-1:0]   widx_ff, widx_in;
   section_type            sec_ff, sec_in;
   logic                   done_ff, done_in;

   logic [63:0]            shifted;
   logic [LEN_WIDTH-1:0]   widx_next;
   logic [LEN_WIDTH-1:0]   len_cur;
   logic                   word_done;
   logic                   item_valid;
   logic                   err_valid;
   status_type             err_code;
   rsp_item_type           item;
   rsp_item_type           status_item;

   assign shifted   = {in_byte, asm_ff[63:8]};
   assign widx_next = widx_ff + LEN_WIDTH'(1);
   assign word_done = (lane_ff == 2'd3);

   always_comb begin
      case (sec_ff)
         SEC_FEATURES: len_cur = LEN_WIDTH'(FEATURE_WORDS);
         SEC_SPECTRUM: len_cur = spec_len_ff;
         default:      len_cur = wave_len_ff;
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      lane_in     = lane_ff;
      asm_in      = asm_ff;
      spec_len_in = spec_len_ff;
      wave_len_in = wave_len_ff;
      widx_in     = widx_ff;
      sec_in      = sec_ff;
      done_in     = done_ff;
      item        = '0;
      item_valid  = 1'b0;
      err_valid   = 1'b0;
      err_code    = ST_OK;

      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               asm_in           = shifted;
               item.result_type = RT_FIELD;
               item_valid       = 1'b1;
               case (pos_ff)
                  POS_FLAGS: begin
                     item.field_id = FID_FLAGS;
                     item.value    = {48'd0, shifted[63:48]};
                  end
                  POS_SEQUENCE: begin
                     item.field_id = FID_SEQUENCE;
                     item.value    = {32'd0, shifted[63:32]};
                  end
                  POS_TIMESTAMP: begin
                     item.field_id = FID_TIMESTAMP;
                     item.value    = {32'd0, shifted[63:32]};
                  end
                  POS_BEAT: begin
                     item.field_id = FID_BEAT;
                     item.value    = shifted;
                  end
                  POS_ONSET: begin
                     item.field_id = FID_ONSET;
                     item.value    = shifted;
                  end
                  POS_DROP: begin
                     item.field_id = FID_DROP;
                     item.value    = shifted;
                  end
                  POS_SECTION: begin
                     item.field_id = FID_SECTION;
                     item.value    = shifted;
                  end
                  default: begin
                     item       = '0;
                     item_valid = 1'b0;
                  end
               endcase

               if (pos_ff == POS_MAGIC && shifted[63:32] != expected_magic) begin
                  err_valid = 1'b1;
                  err_code  = ST_MAGIC;
               end else if (pos_ff == POS_VERSION &&
                            shifted[63:48] != expected_version) begin
                  err_valid = 1'b1;
                  err_code  = ST_VERSION;
               end else if (pos_ff == POS_COUNTS) begin
                  if (shifted[15:0] != 16'(FEATURE_WORDS) ||
                      shifted[31:16] > 16'(MAX_SPECTRUM_WORDS) ||
                      shifted[47:32] > 16'(MAX_WAVEFORM_WORDS)) begin
                     err_valid = 1'b1;
                     err_code  = ST_DIMENSIONS;
                  end else begin
                     spec_len_in = shifted[16 +: LEN_WIDTH];
                     wave_len_in = shifted[32 +: LEN_WIDTH];
                     phase_in    = PH_PAYLOAD;
                     lane_in     = 2'd0;
                     sec_in      = SEC_FEATURES;
                     widx_in     = '0;
                     done_in     = 1'b0;
                     // feature section is never empty, so a payload is owed
                     if (in_last) begin
                        err_valid = 1'b1;
                        err_code  = ST_SIZE;
                     end
                  end
               end else if (in_last) begin
                  err_valid = 1'b1;
                  if (pos_ff < POS_MAGIC) begin
                     err_code = ST_MAGIC;
                  end else if (pos_ff < POS_VERSION) begin
                     err_code = ST_VERSION;
                  end else begin
                     err_code = ST_TRUNCATED;
                  end
               end else begin
                  pos_in = pos_ff + POS_WIDTH'(1);
               end
            end

            PH_PAYLOAD: begin
               if (done_ff) begin
                  err_valid = 1'b1;
                  err_code  = ST_SIZE;
               end else begin
                  asm_in  = shifted;
                  lane_in = lane_ff + 2'd1;
                  if (word_done) begin
                     item_valid       = 1'b1;
                     item.result_type = RT_WORD;
                     item.section     = sec_ff;
                     item.word_index  = widx_ff[7:0];
                     item.value       = {32'd0, shifted[63:32]};
                     if (widx_next == len_cur) begin
                        widx_in = '0;
                        case (sec_ff)
                           SEC_FEATURES: begin
                              if (spec_len_ff != '0) begin
                                 sec_in = SEC_SPECTRUM;
                              end else if (wave_len_ff != '0) begin
                                 sec_in = SEC_WAVEFORM;
                              end else begin
                                 done_in = 1'b1;
                              end
                           end
                           SEC_SPECTRUM: begin
                              if (wave_len_ff != '0) begin
                                 sec_in = SEC_WAVEFORM;
                              end else begin
                                 done_in = 1'b1;
                              end
                           end
                           default: done_in = 1'b1;
                        endcase
                     end else begin
                        widx_in = widx_next;
                     end
                  end
                  if (in_last) begin
                     err_valid = 1'b1;
                     err_code  = (word_done && done_in) ? ST_OK : ST_SIZE;
                  end
               end
            end

            default: ;  // discard until the final byte
         endcase

         // every final byte closes the packet; an error before it discards
         if (in_last) begin
            phase_in    = PH_HEADER;
            pos_in      = '0;
            lane_in     = 2'd0;
            spec_len_in = '0;
            wave_len_in = '0;
            widx_in     = '0;
            sec_in      = SEC_FEATURES;
            done_in     = 1'b0;
         end else if (err_valid) begin
            phase_in = PH_DISCARD;
         end
      end
   end

   always_comb begin
      status_item             = '0;
      status_item.result_type = RT_STATUS;
      status_item.status      = err_code;
      status_item.run_last    = 1'b1;
   end

   always_comb begin
      batch.count  = {1'b0, item_valid} + {1'b0, err_valid};
      batch.first  = status_item;
      batch.second = status_item;
      if (item_valid) begin
         batch.first          = item;
         batch.first.run_last = !err_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         pos_ff      <= '0;
         lane_ff     <= 2'd0;
         spec_len_ff <= '0;
         wave_len_ff <= '0;
         widx_ff     <= '0;
         sec_ff      <= SEC_FEATURES;
         done_ff     <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         lane_ff     <= lane_in;
         spec_len_ff <= spec_len_in;
         wave_len_ff <= wave_len_in;
         widx_ff     <= widx_in;
         sec_ff      <= sec_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      asm_ff <= asm_in;
   end

endmodule

`default_nettype wire

// ----- rtl/ffpp_result_stage.sv -----
// Result register with one skid slot for the second result of a byte.
`default_nettype none

module ffpp_result_stage import ffpp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  rsp_batch_type batch,
   input  logic          rsp_stall,
   output logic          req_stall,
   output logic          rsp_valid,
   output rsp_item_type  rsp_item
);

   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_ff, out_in;
   logic         hold_valid_ff, hold_valid_in;
   rsp_item_type hold_ff, hold_in;
   logic         pop;

   assign pop       = out_valid_ff && !rsp_stall;
   // a new byte needs the output register free this cycle and an empty skid slot
   assign req_stall = hold_valid_ff || (out_valid_ff && rsp_stall);
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (pop) begin
         out_valid_in = 1'b0;
      end
      if (hold_valid_ff) begin
         if (!out_valid_ff || pop) begin
            out_in        = hold_ff;
            out_valid_in  = 1'b1;
            hold_valid_in = 1'b0;
         end
      end else if (batch.count != 2'd0) begin
         out_in       = batch.first;
         out_valid_in = 1'b1;
         if (batch.count == 2'd2) begin
            hold_in       = batch.second;
            hold_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   a_hold_implies_out: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> out_valid_ff)
      else $error("skid slot full while output register empty");

   a_hold_is_status: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (hold_ff.result_type == RT_STATUS && hold_ff.run_last))
      else $error("second result of a byte is not a closing status");

   a_pair_first_not_last: assert property (@(posedge clock) disable iff (reset)
      (!hold_valid_ff ##1 hold_valid_ff) |-> !out_ff.run_last)
      else $error("first result of a pair marked as last");

endmodule

`default_nettype wire

// ----- rtl/feature_frame_packet_parser_unit.sv -----
// Top level of the feature frame packet parser: config registers and channels.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_in_byte, req_in_last
//   rsp      out        rsp_valid/rsp_stall   rsp_result_type .. rsp_run_last
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// One byte per cycle while req_stall is low; a byte's first result is registered and shows in the next cycle.
// A byte with two results (an item plus the packet status) holds req while the second waits in the skid slot.
// Reset clears packet state, the output stage and both config registers.
// rsp_stall backs up into req_stall in the same cycle through the output register.
`default_nettype none

module feature_frame_packet_parser_unit import ffpp_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_in_byte,
   input  logic                       req_in_last,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_result_type,
   output logic [2:0]                 rsp_field_id,
   output logic [1:0]                 rsp_section,
   output logic [7:0]                 rsp_word_index,
   output logic [63:0]                rsp_value,
   output logic [2:0]                 rsp_status,
   output logic                       rsp_run_last,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_data
);

   logic [31:0]   magic_ff, magic_in;
   logic [15:0]   version_ff, version_in;
   logic          req_accept;
   rsp_batch_type batch;
   rsp_item_type  rsp_item;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      magic_in   = magic_ff;
      version_in = version_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAGIC:   magic_in   = csr_data;
            CSR_VERSION: version_in = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= '0;
         version_ff <= '0;
      end else begin
         magic_ff   <= magic_in;
         version_ff <= version_in;
      end
   end

   ffpp_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_accept),
      .in_byte          (req_in_byte),
      .in_last          (req_in_last),
      .expected_magic   (magic_ff),
      .expected_version (version_ff),
      .batch            (batch)
   );

   ffpp_result_stage u_result_stage (
      .clock     (clock),
      .reset     (reset),
      .batch     (batch),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign rsp_result_type = rsp_item.result_type;
   assign rsp_field_id    = rsp_item.field_id;
   assign rsp_section     = rsp_item.section;
   assign rsp_word_index  = rsp_item.word_index;
   assign rsp_value       = rsp_item.value;
   assign rsp_status      = rsp_item.status;
   assign rsp_run_last    = rsp_item.run_last;

endmodule

`default_nettype wire

// ----- bench/tb_feature_frame_packet_parser_unit.sv -----
// Self-checking testbench for the feature frame packet parser: byte-level predictor plus scoreboard.
module tb_feature_frame_packet_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ffpp_pkg::*;

   localparam int CYCLE_LIMIT       = 1_000_000;
   localparam int RANDOM_PHASES     = 3;
   localparam int FRAMES_PER_PHASE  = 1;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER_RESULT = 60;
   localparam int SETTLE_CYCLES     = 8;

   typedef logic [7:0] byte_queue_type[$];
   typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_DISCARD} parse_phase_type;

   class packet_parse_checker;
      logic [31:0]     magic_reg;
      logic [15:0]     version_reg;
      parse_phase_type phase;
      logic [11:0]     pos;
      logic [63:0]     shift_reg;
      logic [8:0]      spec_len;
      logic [8:0]      wave_len;
      logic [9:0]      word_count;
      rsp_item_type    batch[$];
      rsp_item_type    expected_results[$];
      int              fail_count;

      function new();
         magic_reg   = '0;
         version_reg = '0;
         fail_count  = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         phase      = PH_HEADER;
         pos        = '0;
         shift_reg  = '0;
         spec_len   = '0;
         wave_len   = '0;
         word_count = '0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
         if (idx == CSR_MAGIC) begin
            magic_reg = data;
         end else if (idx == CSR_VERSION) begin
            version_reg = data[15:0];
         end
      endfunction

      function void emit(result_kind_type kind, field_id_type fid, section_type sec,
                         logic [7:0] idx, logic [63:0] val, status_type st);
         rsp_item_type item;
         item.result_type = kind;
         item.field_id    = fid;
         item.section     = sec;
         item.word_index  = idx;
         item.value       = val;
         item.status      = st;
         item.run_last    = 1'b0;
         batch = {batch, item};
      endfunction

      // Predicts the results of one accepted byte; returns 0 for a discarded byte.
      function bit parse_byte(logic [7:0] b, logic last);
         logic [63:0]          r;
         logic [9:0]           total;
         logic [9:0]           idx;
         logic                 done;
         logic                 has_status;
         status_type           st;
         section_type          sec;
         logic [7:0]           wi;
         logic [POS_WIDTH-1:0] hpos;
         if (phase == PH_DISCARD) begin
            if (last) clear_packet();
            return 1'b0;
         end
         has_status = 1'b0;
         st = ST_OK;
         if (phase == PH_HEADER) begin
            hpos = POS_WIDTH'(pos);
            r = {b, shift_reg[63:8]};
            shift_reg = r;
            case (hpos)
               POS_FLAGS:     emit(RT_FIELD, FID_FLAGS, SEC_FEATURES, '0, r >> 48, ST_OK);
               POS_SEQUENCE:  emit(RT_FIELD, FID_SEQUENCE, SEC_FEATURES, '0, r >> 32, ST_OK);
               POS_TIMESTAMP: emit(RT_FIELD, FID_TIMESTAMP, SEC_FEATURES, '0, r >> 32, ST_OK);
               POS_BEAT:      emit(RT_FIELD, FID_BEAT, SEC_FEATURES, '0, r, ST_OK);
               POS_ONSET:     emit(RT_FIELD, FID_ONSET, SEC_FEATURES, '0, r, ST_OK);
               POS_DROP:      emit(RT_FIELD, FID_DROP, SEC_FEATURES, '0, r, ST_OK);
               POS_SECTION:   emit(RT_FIELD, FID_SECTION, SEC_FEATURES, '0, r, ST_OK);
               default: ;
            endcase
            if (hpos == POS_MAGIC && r[63:32] != magic_reg) begin
               has_status = 1'b1;
               st = ST_MAGIC;
            end else if (hpos == POS_VERSION && r[63:48] != version_reg) begin
               has_status = 1'b1;
               st = ST_VERSION;
            end else if (hpos == POS_COUNTS) begin
               if (r[15:0] != 16'(FEATURE_WORDS) || r[31:16] > 16'(MAX_SPECTRUM_WORDS) ||
                   r[47:32] > 16'(MAX_WAVEFORM_WORDS)) begin
                  has_status = 1'b1;
                  st = ST_DIMENSIONS;
               end else begin
                  spec_len   = r[24:16];
                  wave_len   = r[40:32];
                  word_count = '0;
                  phase      = PH_PAYLOAD;
                  pos        = 12'(HEADER_BYTES);
                  total      = 10'(FEATURE_WORDS) + 10'(spec_len) + 10'(wave_len);
                  if (last) begin
                     has_status = 1'b1;
                     st = (total == 0) ? ST_OK : ST_SIZE;
                  end
               end
            end else if (last) begin
               has_status = 1'b1;
               st = (hpos <= 2) ? ST_MAGIC : (hpos <= 4) ? ST_VERSION : ST_TRUNCATED;
            end else begin
               pos = pos + 12'd1;
            end
         end else begin
            total = 10'(FEATURE_WORDS) + 10'(spec_len) + 10'(wave_len);
            if (word_count >= total) begin
               // byte beyond the last expected word
               has_status = 1'b1;
               st = ST_SIZE;
            end else begin
               r = {b, shift_reg[63:8]};
               shift_reg = r;
               done = (pos[1:0] == 2'd3);
               pos = pos + 12'd1;
               if (done) begin
                  idx = word_count;
                  if (idx < 10'(FEATURE_WORDS)) begin
                     sec = SEC_FEATURES;
                     wi  = 8'(idx);
                  end else if (idx < 10'(FEATURE_WORDS) + 10'(spec_len)) begin
                     sec = SEC_SPECTRUM;
                     wi  = 8'(idx - 10'(FEATURE_WORDS));
                  end else begin
                     sec = SEC_WAVEFORM;
                     wi  = 8'(idx - 10'(FEATURE_WORDS) - 10'(spec_len));
                  end
                  emit(RT_WORD, FID_FLAGS, sec, wi, r >> 32, ST_OK);
                  word_count = idx + 10'd1;
               end
               if (last) begin
                  has_status = 1'b1;
                  st = (done && word_count == total) ? ST_OK : ST_SIZE;
               end
            end
         end
         if (has_status) begin
            emit(RT_STATUS, FID_FLAGS, SEC_FEATURES, '0, '0, st);
            if (last) clear_packet();
            else phase = PH_DISCARD;
         end
         if (batch.size() > 0) begin
            batch[$].run_last = 1'b1;
            expected_results = {expected_results, batch};
            batch.delete();
         end
         return 1'b1;
      endfunction

      function string describe(rsp_item_type it);
         return $sformatf("type %0d field %0d section %0d index %0d value %h status %0d last %b",
                          it.result_type, it.field_id, it.section, it.word_index, it.value,
                          it.status, it.run_last);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected result: %s", describe(got));
            return;
         end
         want = expected_results.pop_front();
         if (got.result_type !== want.result_type || got.field_id !== want.field_id ||
             got.section !== want.section || got.word_index !== want.word_index ||
             got.value !== want.value || got.status !== want.status ||
             got.run_last !== want.run_last) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("result mismatch");
               $display("  expected %s", describe(want));
               $display("  actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_in_byte = '0;
   logic                       req_in_last = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [1:0]                 rsp_result_type;
   logic [2:0]                 rsp_field_id;
   logic [1:0]                 rsp_section;
   logic [7:0]                 rsp_word_index;
   logic [63:0]                rsp_value;
   logic [2:0]                 rsp_status;
   logic                       rsp_run_last;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0]                csr_data = '0;

   packet_parse_checker frame_check;
   logic [31:0] cur_magic = '0;
   logic [15:0] cur_version = '0;
   int          tx_burst = 0;
   int          rx_burst = 0;
   int          cycle_count = 0;

   feature_frame_packet_parser_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_in_last     (req_in_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_type (rsp_result_type),
      .rsp_field_id    (rsp_field_id),
      .rsp_section     (rsp_section),
      .rsp_word_index  (rsp_word_index),
      .rsp_value       (rsp_value),
      .rsp_status      (rsp_status),
      .rsp_run_last    (rsp_run_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // Idle cycles before the next transaction; now and then a stretch with none.
   function automatic int draw_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(16, 64);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   function automatic int draw_len(int max_words);
      int r;
      r = $urandom_range(0, 49);
      if (r == 0) return $urandom_range(max_words - 56, max_words);
      if (r < 6) return $urandom_range(5, 40);
      return $urandom_range(0, 4);
   endfunction

   function automatic void put_le(inout byte_queue_type q, input logic [63:0] v, input int n);
      for (int k = 0; k < n; k++) q = {q, v[8*k +: 8]};
   endfunction

   // fill < 0 gives random bytes for everything but magic, version and counts
   function automatic byte_queue_type make_frame(int fc, int sc, int wc, int words, int fill);
      byte_queue_type q;
      put_le(q, 64'(cur_magic), 4);
      put_le(q, 64'(cur_version), 2);
      for (int k = 6; k < 48; k++) q = {q, (fill < 0 ? 8'($urandom) : 8'(fill))};
      put_le(q, 64'(fc), 2);
      put_le(q, 64'(sc), 2);
      put_le(q, 64'(wc), 2);
      for (int k = 0; k < 2 + 4 * words; k++) begin
         q = {q, (fill < 0 ? 8'($urandom) : 8'(fill))};
      end
      return q;
   endfunction

   function automatic byte_queue_type trim_frame(byte_queue_type q, int n);
      while (q.size() > n) void'(q.pop_back());
      return q;
   endfunction

   function automatic byte_queue_type random_frame();
      byte_queue_type q;
      int kind;
      int fc;
      int sc;
      int wc;
      kind = $urandom_range(0, 99);
      fc = FEATURE_WORDS;
      sc = draw_len(MAX_SPECTRUM_WORDS);
      wc = draw_len(MAX_WAVEFORM_WORDS);
      if (kind >= 77 && kind < 83) begin
         case ($urandom_range(0, 2))
            0: begin
               fc = $urandom_range(0, 65535);
               if (fc == FEATURE_WORDS) fc++;
            end
            1: sc = $urandom_range(0, 1) ? MAX_SPECTRUM_WORDS + 1 : $urandom_range(257, 65535);
            default: wc = $urandom_range(0, 1) ? MAX_WAVEFORM_WORDS + 1
                                               : $urandom_range(257, 65535);
         endcase
         return make_frame(fc, sc, wc, $urandom_range(0, 3), -1);
      end
      q = make_frame(fc, sc, wc, FEATURE_WORDS + sc + wc, -1);
      if (kind < 55) begin
         return q;
      end else if (kind < 62) begin
         q[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
      end else if (kind < 69) begin
         q[$urandom_range(4, 5)] ^= 8'(1 << $urandom_range(0, 7));
      end else if (kind < 77) begin
         q = trim_frame(q, $urandom_range(1, HEADER_BYTES - 1));
      end else if (kind < 91) begin
         q = trim_frame(q, $urandom_range(HEADER_BYTES, q.size() - 1));
      end else if (kind < 96) begin
         repeat ($urandom_range(1, 4)) q = {q, 8'($urandom)};
      end else begin
         q.delete();
         repeat ($urandom_range(1, 64)) q = {q, 8'($urandom)};
      end
      return q;
   endfunction

   task automatic send_frame(input byte_queue_type frame);
      int gap;
      for (int i = 0; i < frame.size(); i++) begin
         gap = draw_gap(tx_burst);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_in_byte <= frame[i];
         req_in_last <= (i == frame.size() - 1);
         do @(posedge clock); while (req_stall);
      end
   endtask

   task automatic program_regs(input logic [31:0] magic, input logic [15:0] version);
      logic [CSR_INDEX_WIDTH-1:0] idx[2];
      logic [31:0]                data[2];
      idx  = '{CSR_MAGIC, CSR_VERSION};
      // upper half of the version write is junk the block must ignore
      data = '{magic, {16'($urandom), version}};
      for (int k = 0; k < 2; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= data[k];
         do @(posedge clock); while (!csr_ready);
         frame_check.write_reg(idx[k], data[k]);
      end
      csr_valid   <= 1'b0;
      cur_magic   = magic;
      cur_version = version;
   endtask

   task automatic wait_idle();
      // let the monitor take the last accepted byte first
      @(posedge clock);
      while (frame_check.expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            void'(frame_check.parse_byte(req_in_byte, req_in_last));
         end
         if (rsp_valid && !rsp_stall) begin
            frame_check.check_result({rsp_result_type, rsp_field_id, rsp_section,
                                      rsp_word_index, rsp_value, rsp_status, rsp_run_last});
         end
      end
   end

   initial begin : receiver
      int gap;
      int taken;
      bit held;
      taken = 0;
      held  = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         // one long back-pressure stretch so the block fills and stalls its input
         if (!held && taken >= HOLD_AFTER_RESULT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         gap = draw_gap(rx_burst);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      byte_queue_type frame;
      int             cut_points[10];
      frame_check = new();
      cut_points = '{1, 3, 4, 5, 6, 8, 48, 55, 56, 66};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part, registers at their reset values
      send_frame(make_frame(FEATURE_WORDS, 0, 0, FEATURE_WORDS, -1));
      send_frame(make_frame(FEATURE_WORDS, 2, 3, FEATURE_WORDS + 5, 0));
      // final byte inside magic, version, header fields and payload
      foreach (cut_points[k]) begin
         send_frame(trim_frame(make_frame(FEATURE_WORDS, 0, 0, FEATURE_WORDS, -1),
                               cut_points[k]));
      end
      frame = make_frame(FEATURE_WORDS, 0, 0, FEATURE_WORDS, -1);
      frame[0] ^= 8'h01;
      send_frame(trim_frame(frame, 10));
      frame = make_frame(FEATURE_WORDS, 0, 0, FEATURE_WORDS, -1);
      frame[5] ^= 8'h80;
      send_frame(trim_frame(frame, 10));
      send_frame(make_frame(FEATURE_WORDS - 1, 0, 0, 2, -1));
      send_frame(make_frame(FEATURE_WORDS, MAX_SPECTRUM_WORDS + 1, 0, 0, -1));
      send_frame(make_frame(FEATURE_WORDS, 0, MAX_WAVEFORM_WORDS + 1, 0, -1));
      // bytes after the last payload word
      frame = make_frame(FEATURE_WORDS, 0, 1, FEATURE_WORDS + 1, -1);
      frame = {frame, 8'($urandom)};
      send_frame(frame);
      frame = make_frame(FEATURE_WORDS, 1, 0, FEATURE_WORDS + 1, -1);
      repeat (3) frame = {frame, 8'($urandom)};
      send_frame(frame);
      req_valid <= 1'b0;
      wait_idle();

      for (int p = 1; p <= RANDOM_PHASES; p++) begin
         case (p)
            1: program_regs(32'hFFFF_FFFF, 16'hFFFF);
            2: program_regs(32'h0, 16'h0);
            default: program_regs($urandom, 16'($urandom));
         endcase
         repeat (FRAMES_PER_PHASE) send_frame(random_frame());
         req_valid <= 1'b0;
         wait_idle();
      end

      if (frame_check.fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ffpp_pkg.sv
rtl/ffpp_parser.sv
rtl/ffpp_result_stage.sv
rtl/feature_frame_packet_parser_unit.sv
bench/tb_feature_frame_packet_parser_unit.sv
